[rtl/kfli_pkg.sv]
package kfli_pkg;

   // table geometry
   localparam int MAX_FRAMES  = 16;
   localparam int TIME_BITS   = 16;
   localparam int IDX_BITS    = $clog2(MAX_FRAMES);
   localparam int VALUE_BITS  = 32;
   localparam int ENTRY_WIDTH = TIME_BITS + VALUE_BITS;

   // fixed field widths of the stream beats
   localparam int CMD_BITS    = 1;
   localparam int ENTRY_BITS  = 4;
   localparam int KEY_BITS    = 16;
   localparam int COUNT_BITS  = 5;

   // request tdata layout, lowest field first
   localparam int ENTRY_LSB   = 0;
   localparam int KEY_T_LSB   = ENTRY_LSB + ENTRY_BITS;
   localparam int KEY_V_LSB   = KEY_T_LSB + KEY_BITS;
   localparam int ELAPSED_LSB = KEY_V_LSB + VALUE_BITS;
   localparam int REQ_USED    = ELAPSED_LSB + KEY_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = VALUE_BITS;

   // counting width wide enough for the saturated frame count
   localparam int CNT_BITS = (IDX_BITS + 1 > COUNT_BITS) ? IDX_BITS + 1 : COUNT_BITS;

   // divider and multiplier
   localparam int FRAC_BITS  = 16;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int STEP_BITS  = $clog2(FRAC_BITS);
   localparam int DIFF_BITS  = VALUE_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + QUO_BITS + 1;
   localparam logic [QUO_BITS-1:0] FRAC_ONE = QUO_BITS'(1) << FRAC_BITS;

   // request kinds carried on tuser
   localparam logic [CMD_BITS-1:0] CMD_WRITE  = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } kfli_state_type;

endpackage

[rtl/keyframe_linear_interpolator_core.sv]
// Piecewise linear keyframe interpolator. A write beat (tuser = 0) stores one
// keyframe, a key time in ms and a signed Q16.16 value, into slot entry_index
// of a 16-entry table; entries must be loaded in strictly ascending time order
// and the csr register sets how many entries, from slot 0, are in use (values
// above 16 count as 16). A sample beat (tuser = 1) walks the table for the
// first frame whose time is at or after elapsed_ms and interpolates from the
// previous frame's value (the frame's own value for the first frame, so the
// first value holds before it) with a Q1.16 fraction. Every request beat gives
// exactly one response beat; tuser on the response is 1 only when a segment
// was found, otherwise tdata is zero. Timing: one request is in flight at a
// time. A write or an empty table goes straight to the done state. A sample
// searches from slot 0 to the slot that matched: the table ram delivers one
// entry per cycle for the search, then a subtractor runs a 16-step restoring
// divide (skipped when the sample sits on the segment end), then one multiply
// and one add. The response sits in an output register, so the next request
// is taken while it waits for rsp_tready.
module keyframe_linear_interpolator_core (
   input  logic                                clock,
   input  logic                                reset,
   // request: entry_index, key_time, key_value, elapsed_ms, zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kfli_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // request kind: cmd
   input  logic [kfli_pkg::CMD_BITS-1:0]       req_tuser,
   // response: value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kfli_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // response flag: valid_res
   output logic                                rsp_tuser,
   // frame_count register
   input  logic                                csr_wr_en,
   input  logic [kfli_pkg::COUNT_BITS-1:0]     csr_wr_data
);

   localparam int TB = kfli_pkg::TIME_BITS;
   localparam int VB = kfli_pkg::VALUE_BITS;
   localparam int IB = kfli_pkg::IDX_BITS;
   localparam int CB = kfli_pkg::CNT_BITS;

   kfli_pkg::kfli_state_type state_ff, state_in;

   logic [kfli_pkg::COUNT_BITS-1:0] frame_count_ff;

   // search pipeline
   logic [IB-1:0]           rd_addr_ff, rd_addr_in;
   logic [IB-1:0]           chk_ff, chk_in;
   logic                    pend_ff, pend_in;
   logic [TB-1:0]           samp_time_ff, samp_time_in;
   logic [TB-1:0]           prev_time_ff, prev_time_in;
   logic signed [VB-1:0]    prev_value_ff, prev_value_in;

   // segment operands
   logic [TB-1:0]           beg_ff, beg_in;
   logic [TB-1:0]           end_ff, end_in;
   logic signed [VB-1:0]    from_ff, from_in;
   logic signed [VB-1:0]    to_ff, to_in;

   // divider / multiplier
   logic [TB-1:0]                          rem_ff, rem_in;
   logic [kfli_pkg::QUO_BITS-1:0]          quo_ff, quo_in;
   logic [kfli_pkg::STEP_BITS-1:0]         step_ff, step_in;
   logic signed [kfli_pkg::PROD_BITS-1:0]  prod_ff, prod_in;

   // finished result and output register
   logic [VB-1:0]  res_value_ff, res_value_in;
   logic           res_flag_ff, res_flag_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0]  rsp_value_ff, rsp_value_in;
   logic           rsp_flag_ff, rsp_flag_in;

   // field views of the request beat
   logic [kfli_pkg::ENTRY_BITS-1:0] f_entry;
   logic [kfli_pkg::KEY_BITS-1:0]   f_key_time;
   logic [VB-1:0]                   f_key_value;
   logic [kfli_pkg::KEY_BITS-1:0]   f_elapsed;

   assign f_entry     = req_tdata[kfli_pkg::ENTRY_LSB +: kfli_pkg::ENTRY_BITS];
   assign f_key_time  = req_tdata[kfli_pkg::KEY_T_LSB +: kfli_pkg::KEY_BITS];
   assign f_key_value = req_tdata[kfli_pkg::KEY_V_LSB +: VB];
   assign f_elapsed   = req_tdata[kfli_pkg::ELAPSED_LSB +: kfli_pkg::KEY_BITS];

   logic req_fire;
   logic rsp_free;
   assign req_tready = (state_ff == kfli_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // saturated count of entries in use
   logic [CB-1:0] cnt_ext;
   logic [CB-1:0] n_used;
   logic          table_empty;
   logic          last_entry;
   assign cnt_ext     = CB'(frame_count_ff);
   assign n_used      = (cnt_ext > CB'(kfli_pkg::MAX_FRAMES)) ?
                        CB'(kfli_pkg::MAX_FRAMES) : cnt_ext;
   assign table_empty = (n_used == '0);
   assign last_entry  = ((CB'(chk_ff) + CB'(1)) == n_used);

   // keyframe table: time in the low bits, value above
   logic                              wr_en;
   logic [kfli_pkg::ENTRY_WIDTH-1:0]  rd_data;
   logic [TB-1:0]                     rd_time;
   logic signed [VB-1:0]              rd_value;

   assign wr_en = req_fire && (req_tuser == kfli_pkg::CMD_WRITE) &&
                  ((kfli_pkg::ENTRY_BITS + 1)'(f_entry) <
                   (kfli_pkg::ENTRY_BITS + 1)'(kfli_pkg::MAX_FRAMES));

   kfli_ram #(
      .WIDTH (kfli_pkg::ENTRY_WIDTH),
      .DEPTH (kfli_pkg::MAX_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IB'(f_entry)),
      .wr_data ({f_key_value, TB'(f_key_time)}),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_time  = rd_data[TB-1:0];
   assign rd_value = rd_data[kfli_pkg::ENTRY_WIDTH-1:TB];

   logic hit;
   assign hit = pend_ff && (rd_time >= samp_time_ff);

   // subtractors: span and position in prep, trial subtract in the divide
   logic [TB-1:0] span;
   logic [TB-1:0] seg_pos;
   logic [TB:0]   shifted;
   logic [TB:0]   trial;
   assign span    = (end_ff > beg_ff) ? (end_ff - beg_ff) : '0;
   assign seg_pos = samp_time_ff - beg_ff;
   assign shifted = {rem_ff, 1'b0};
   assign trial   = shifted - {1'b0, span};

   logic signed [kfli_pkg::DIFF_BITS-1:0] diff;
   assign diff = kfli_pkg::DIFF_BITS'(to_ff) - kfli_pkg::DIFF_BITS'(from_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kfli_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == kfli_pkg::CMD_SAMPLE && !table_empty) begin
                  state_in = kfli_pkg::ST_SCAN;
               end else begin
                  state_in = kfli_pkg::ST_DONE;
               end
            end
         end
         kfli_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = kfli_pkg::ST_PREP;
            end else if (pend_ff && last_entry) begin
               state_in = kfli_pkg::ST_DONE;
            end
         end
         kfli_pkg::ST_PREP: begin
            priority if (span == '0 || samp_time_ff < beg_ff) begin
               state_in = kfli_pkg::ST_DONE;
            end else if (seg_pos == span) begin
               state_in = kfli_pkg::ST_MUL;
            end else begin
               state_in = kfli_pkg::ST_DIV;
            end
         end
         kfli_pkg::ST_DIV: begin
            if (step_ff == '1) begin
               state_in = kfli_pkg::ST_MUL;
            end
         end
         kfli_pkg::ST_MUL: state_in = kfli_pkg::ST_SUM;
         kfli_pkg::ST_SUM: state_in = kfli_pkg::ST_DONE;
         kfli_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = kfli_pkg::ST_IDLE;
            end
         end
         default: state_in = kfli_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      rd_addr_in    = rd_addr_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      samp_time_in  = samp_time_ff;
      prev_time_in  = prev_time_ff;
      prev_value_in = prev_value_ff;
      beg_in        = beg_ff;
      end_in        = end_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      res_value_in  = res_value_ff;
      res_flag_in   = res_flag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_flag_in   = rsp_flag_ff;

      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         kfli_pkg::ST_IDLE: begin
            if (req_fire) begin
               // writes, and samples of an empty table, answer invalid
               res_value_in = '0;
               res_flag_in  = 1'b0;
               samp_time_in = TB'(f_elapsed);
               rd_addr_in   = '0;
               pend_in      = 1'b0;
            end
         end
         kfli_pkg::ST_SCAN: begin
            // one table read issued per cycle, checked in the following cycle
            rd_addr_in = rd_addr_ff + IB'(1);
            chk_in     = rd_addr_ff;
            pend_in    = 1'b1;
            if (hit) begin
               to_in  = rd_value;
               end_in = rd_time;
               if (chk_ff == '0) begin
                  from_in = rd_value;
                  beg_in  = '0;
               end else begin
                  from_in = prev_value_ff;
                  beg_in  = prev_time_ff;
               end
            end else if (pend_ff) begin
               prev_time_in  = rd_time;
               prev_value_in = rd_value;
            end
         end
         kfli_pkg::ST_PREP: begin
            rem_in  = seg_pos;
            quo_in  = (seg_pos == span) ? kfli_pkg::FRAC_ONE : '0;
            step_in = '0;
            if (span == '0 || samp_time_ff < beg_ff) begin
               res_value_in = to_ff;
               res_flag_in  = 1'b1;
            end
         end
         kfli_pkg::ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            step_in = step_ff + kfli_pkg::STEP_BITS'(1);
            if (!trial[TB]) begin
               rem_in = trial[TB-1:0];
               quo_in = {quo_ff[kfli_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted[TB-1:0];
               quo_in = {quo_ff[kfli_pkg::QUO_BITS-2:0], 1'b0};
            end
         end
         kfli_pkg::ST_MUL: begin
            prod_in = diff * $signed({1'b0, quo_ff});
         end
         kfli_pkg::ST_SUM: begin
            // arithmetic shift of the product floors toward minus infinity
            res_value_in = from_ff + prod_ff[kfli_pkg::FRAC_BITS +: VB];
            res_flag_in  = 1'b1;
         end
         kfli_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_flag_in  = res_flag_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase

      // search ran off the end of the used entries
      if (state_ff == kfli_pkg::ST_SCAN && !hit && pend_ff && last_entry) begin
         res_value_in = '0;
         res_flag_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kfli_pkg::ST_IDLE;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      chk_ff        <= chk_in;
      samp_time_ff  <= samp_time_in;
      prev_time_ff  <= prev_time_in;
      prev_value_ff <= prev_value_in;
      beg_ff        <= beg_in;
      end_ff        <= end_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      res_value_ff  <= res_value_in;
      res_flag_ff   <= res_flag_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // a held response is never overwritten: the sequencer waits in done
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kfli_pkg::ST_DONE && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == kfli_pkg::ST_DONE))
      else $error("response register overwritten while stalled");

   // a sample of a non-empty table starts the search
   a_sample_scans: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == kfli_pkg::CMD_SAMPLE && !table_empty)
      |=> (state_ff == kfli_pkg::ST_SCAN && !pend_ff && rd_addr_ff == '0))
      else $error("sample did not start the table search");

   // divide remainder stays below the span
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kfli_pkg::ST_DIV) |-> (rem_ff < span))
      else $error("divide remainder out of range");

   // fraction never exceeds one
   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kfli_pkg::ST_MUL) |-> (quo_ff <= kfli_pkg::FRAC_ONE))
      else $error("fraction above one");

   // invalid responses carry a zero value
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid response with nonzero value");

endmodule

[rtl/kfli_ram.sv]
module kfli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
